// ----- rtl/fjb_pkg.sv -----
// shared types and constants for the frame jitter buffer
`default_nettype none
package fjb_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8;

  // operation codes
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_PREDICT = 3'd2;
  localparam logic [2:0] OP_HAS     = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  // register indexes
  localparam logic [1:0] REG_MIN_DELAY    = 2'd0;
  localparam logic [1:0] REG_MAX_DELAY    = 2'd1;
  localparam logic [1:0] REG_TARGET_DEPTH = 2'd2;

  localparam logic [7:0] MIN_DELAY_RST    = 8'd1;
  localparam logic [7:0] MAX_DELAY_RST    = 8'd8;
  localparam logic [7:0] TARGET_DEPTH_RST = 8'd2;

  // band width above target depth
  localparam logic [8:0] BAND = 9'd2;

  localparam int unsigned ENTRY_W = 32 + 64 + 4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] frame_number;
    logic [63:0] payload_in;
    logic [3:0]  payload_length_in;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [63:0] payload_out;
    logic [3:0]  payload_length_out;
    logic [7:0]  delay_frames;
    logic [31:0] highest_frame;
    logic [31:0] lowest_frame;
    logic [6:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [7:0] min_delay;
    logic [7:0] max_delay;
    logic [7:0] target_depth;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_start;
    logic sh_start;
    logic sh_up;
    logic sh_from0;
    logic ins;
    logic cnt_dec;
    logic rd0;
    logic load_low;
    logic exec;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic hit;
    logic pos_lt_count;
    logic will_over;
    logic one_left;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/frame_jitter_buffer.sv -----
// top level of the frame jitter buffer: register port, controller, datapath
//
// Usage: raise start with an item on item while busy is low; the transfer
// happens at that edge and busy rises. Exactly one result follows on result,
// marked by a one-cycle done strobe; busy is already low in that cycle, so
// the next item may be started while the result is shown.
// Each operation runs through the controller: update, clear and unused
// codes execute and finish; has and predict search linearly, one entry
// per cycle; pop searches up to the frame and entries above close the
// gap; push searches, shifts entries above up and writes the entry, and
// drops the oldest entry when the buffer is full.
// The single entry memory takes one read and one write per cycle. The
// result cannot be held off by the receiver.
// Registers at byte address 0 min_delay, 4 max_delay, 8 target_depth,
// written over the APB-style port; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Reset (synchronous, rst high) empties the buffer and loads the register
// defaults; no clearing pass runs over the memory.
`default_nettype none
module frame_jitter_buffer #(
  parameter int unsigned CAPACITY = 120
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fjb_pkg::in_t  item,
  output logic               done,
  output fjb_pkg::out_t      result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fjb_pkg::cfg_t  cfg;
  fjb_pkg::cmd_t  cmd;
  fjb_pkg::stat_t stat;

  assign pready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_delay    <= fjb_pkg::MIN_DELAY_RST;
      cfg.max_delay    <= fjb_pkg::MAX_DELAY_RST;
      cfg.target_depth <= fjb_pkg::TARGET_DEPTH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        fjb_pkg::REG_MIN_DELAY:    cfg.min_delay    <= pwdata[7:0];
        fjb_pkg::REG_MAX_DELAY:    cfg.max_delay    <= pwdata[7:0];
        fjb_pkg::REG_TARGET_DEPTH: cfg.target_depth <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      fjb_pkg::REG_MIN_DELAY:    prdata = {24'd0, cfg.min_delay};
      fjb_pkg::REG_MAX_DELAY:    prdata = {24'd0, cfg.max_delay};
      fjb_pkg::REG_TARGET_DEPTH: prdata = {24'd0, cfg.target_depth};
      default:                   prdata = 32'd0;
    endcase
  end

  fjb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op_in(item.operation),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  fjb_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cfg   (cfg),
    .cmd   (cmd),
    .stat  (stat),
    .done  (done),
    .result(result)
  );

endmodule
`default_nettype wire

// ----- rtl/fjb_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module fjb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/fjb_ctrl.sv -----
// sequencing state machine for the frame jitter buffer
`default_nettype none
module fjb_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [2:0]   op_in,
  input  wire fjb_pkg::stat_t stat,
  output logic              busy,
  output fjb_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHUP, S_INS, S_TRIM, S_POPSH, S_RD0, S_RD0W, S_EXEC, S_FIN
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] op;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (op_in == fjb_pkg::OP_PUSH || op_in == fjb_pkg::OP_POP ||
              op_in == fjb_pkg::OP_PREDICT || op_in == fjb_pkg::OP_HAS) begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (op == fjb_pkg::OP_PUSH) begin
            if (stat.hit || !stat.pos_lt_count) begin
              state_next = S_INS;
            end else begin
              cmd.sh_start = 1'b1;
              cmd.sh_up = 1'b1;
              state_next = S_SHUP;
            end
          end else if (op == fjb_pkg::OP_POP && stat.hit) begin
            cmd.sh_start = 1'b1;
            state_next = S_POPSH;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SHUP: begin
        if (stat.shift_done) begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.ins = 1'b1;
        if (stat.will_over) begin
          cmd.sh_start = 1'b1;
          cmd.sh_from0 = 1'b1;
          state_next = S_TRIM;
        end else begin
          state_next = S_FIN;
        end
      end
      S_TRIM: begin
        if (stat.shift_done) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_FIN;
        end
      end
      S_POPSH: begin
        if (stat.shift_done) begin
          cmd.cnt_dec = 1'b1;
          state_next = stat.one_left ? S_FIN : S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd0 = 1'b1;
        state_next = S_RD0W;
      end
      S_RD0W: begin
        cmd.load_low = 1'b1;
        state_next = S_FIN;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and latched operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= fjb_pkg::OP_PUSH;
    end else begin
      state <= state_next;
      if (cmd.latch) begin
        op <= op_in;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fjb_dp.sv -----
// datapath: entry store, scan, shift engine and block state
`default_nettype none
module fjb_dp #(
  parameter int unsigned CAPACITY = 120
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fjb_pkg::in_t  item,
  input  wire fjb_pkg::cfg_t cfg,
  input  wire fjb_pkg::cmd_t cmd,
  output fjb_pkg::stat_t     stat,
  output logic               done,
  output fjb_pkg::out_t      result
);

  localparam int unsigned DEPTH = CAPACITY + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(CAPACITY + 2);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  // latched item
  logic [2:0]  op;
  logic [31:0] f;
  logic [63:0] pay;
  logic [3:0]  len;

  // block state
  logic [CW-1:0] count;
  logic [31:0]   highest;
  logic [31:0]   lowest;
  logic [63:0]   last_pay;
  logic [3:0]    last_len;
  logic [7:0]    delay;

  // scan
  logic          sc_run;
  logic [CW-1:0] sc_addr;
  logic          cmp_v;
  logic [CW-1:0] cmp_idx;
  logic          scan_done;
  logic [CW-1:0] pos;
  logic          hit;
  logic [63:0]   hit_pay;
  logic [3:0]    hit_len;
  logic [31:0]   first_frame;

  // shift engine
  logic          sh_busy;
  logic          sh_up;
  logic [CW-1:0] sh_addr;
  logic [CW-1:0] sh_n;
  logic          wr_pend;
  logic [CW-1:0] wr_addr;

  // ram ports
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [fjb_pkg::ENTRY_W-1:0]  wdata;
  logic [AW-1:0]                raddr;
  logic [fjb_pkg::ENTRY_W-1:0]  rdata;
  logic [31:0]                  rd_frame;
  logic [63:0]                  rd_pay;
  logic [3:0]                   rd_len;

  // item conditioning
  logic [3:0]  len_sat;
  logic [63:0] pay_mask;

  // delay update
  logic [31:0] buffered;
  logic [7:0]  eff_max;
  logic        sh_fin;

  assign {rd_frame, rd_pay, rd_len} = rdata;

  // saturate length and zero bytes past it
  always_comb begin
    len_sat = (item.payload_length_in > 4'(fjb_pkg::PAYLOAD_BYTES)) ?
              4'(fjb_pkg::PAYLOAD_BYTES) : item.payload_length_in;
    for (int b = 0; b < 8; b++) begin
      pay_mask[b*8 +: 8] = (4'(b) < len_sat) ? item.payload_in[b*8 +: 8] : 8'h00;
    end
  end

  assign sh_fin = sh_busy && (sh_n == '0) && !wr_pend;

  // status to controller
  always_comb begin
    stat.scan_done    = scan_done;
    stat.shift_done   = sh_fin;
    stat.hit          = hit;
    stat.pos_lt_count = (pos < count);
    stat.will_over    = !hit && (count >= CAP_C);
    stat.one_left     = (count == ONE);
  end

  // ram address and write selection
  always_comb begin
    if (sh_busy) begin
      raddr = sh_addr[AW-1:0];
    end else if (cmd.rd0) begin
      raddr = '0;
    end else begin
      raddr = sc_addr[AW-1:0];
    end
    if (wr_pend) begin
      we    = 1'b1;
      waddr = wr_addr[AW-1:0];
      wdata = rdata;
    end else begin
      we    = cmd.ins;
      waddr = pos[AW-1:0];
      wdata = {f, pay, len};
    end
  end

  fjb_ram #(
    .WIDTH(fjb_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign buffered = (highest > f) ? (highest - f) : 32'd0;
  assign eff_max  = (cfg.max_delay > cfg.min_delay) ? cfg.max_delay : cfg.min_delay;

  // control registers: scan, shift engine, output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_run    <= 1'b0;
      cmp_v     <= 1'b0;
      scan_done <= 1'b0;
      sh_busy   <= 1'b0;
      wr_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      scan_done <= 1'b0;
      done      <= cmd.finish;
      // pipelined search for first frame not below the key
      if (cmd.scan_start) begin
        sc_run <= (count != '0);
        cmp_v  <= 1'b0;
        if (count == '0) begin
          scan_done <= 1'b1;
        end
      end else if (sc_run) begin
        cmp_v <= (sc_addr < count);
        if (cmp_v && ((rd_frame >= f) || (cmp_idx == count - ONE))) begin
          sc_run    <= 1'b0;
          cmp_v     <= 1'b0;
          scan_done <= 1'b1;
        end
      end
      // copy one entry per cycle
      if (cmd.sh_start) begin
        sh_busy <= 1'b1;
        wr_pend <= 1'b0;
      end else if (sh_busy) begin
        wr_pend <= (sh_n != '0);
        if (sh_fin) begin
          sh_busy <= 1'b0;
        end
      end
    end
  end

  // payload and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      highest  <= '0;
      lowest   <= '0;
      last_pay <= '0;
      last_len <= '0;
      delay    <= fjb_pkg::MIN_DELAY_RST;
    end else begin
      if (cmd.ins) begin
        if (!hit) begin
          count <= count + ONE;
        end
        if (f > highest) begin
          highest <= f;
        end
        lowest   <= (pos == '0) ? f : first_frame;
        last_pay <= pay;
        last_len <= len;
      end
      if (cmd.cnt_dec) begin
        count <= count - ONE;
      end
      if (cmd.load_low) begin
        lowest <= rd_frame;
      end
      if (cmd.exec) begin
        if (op == fjb_pkg::OP_CLEAR) begin
          count    <= '0;
          highest  <= '0;
          lowest   <= '0;
          last_pay <= '0;
          last_len <= '0;
          delay    <= cfg.min_delay;
        end else if (op == fjb_pkg::OP_UPDATE && count != '0) begin
          if (buffered < 32'(cfg.target_depth)) begin
            if (delay < eff_max) begin
              delay <= delay + 8'd1;
            end
          end else if (buffered > 32'({1'b0, cfg.target_depth} + fjb_pkg::BAND)) begin
            if (delay > cfg.min_delay) begin
              delay <= delay - 8'd1;
            end
          end
        end
      end
    end
  end

  // item latch, scan data path, shift addressing, result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= item.operation;
      f   <= item.frame_number;
      pay <= pay_mask;
      len <= len_sat;
    end
    if (cmd.scan_start) begin
      sc_addr <= '0;
      pos     <= '0;
      hit     <= 1'b0;
    end else if (sc_run) begin
      if (sc_addr < count) begin
        sc_addr <= sc_addr + ONE;
      end
      cmp_idx <= sc_addr;
      if (cmp_v) begin
        if (cmp_idx == '0) begin
          first_frame <= rd_frame;
        end
        if (rd_frame >= f) begin
          pos     <= cmp_idx;
          hit     <= (rd_frame == f);
          hit_pay <= rd_pay;
          hit_len <= rd_len;
        end else if (cmp_idx == count - ONE) begin
          pos <= count;
        end
      end
    end
    if (cmd.sh_start) begin
      sh_up <= cmd.sh_up;
      if (cmd.sh_from0) begin
        sh_addr <= ONE;
        sh_n    <= CAP_C;
      end else if (cmd.sh_up) begin
        sh_addr <= count - ONE;
        sh_n    <= count - pos;
      end else begin
        sh_addr <= pos + ONE;
        sh_n    <= count - ONE - pos;
      end
    end else if (sh_busy && sh_n != '0) begin
      wr_addr <= sh_up ? sh_addr + ONE : sh_addr - ONE;
      sh_addr <= sh_up ? sh_addr - ONE : sh_addr + ONE;
      sh_n    <= sh_n - ONE;
    end
    if (cmd.finish) begin
      result.found              <= 1'b0;
      result.payload_out        <= '0;
      result.payload_length_out <= '0;
      case (op)
        fjb_pkg::OP_PUSH, fjb_pkg::OP_CLEAR: begin
          result.found <= 1'b1;
        end
        fjb_pkg::OP_POP, fjb_pkg::OP_HAS: begin
          result.found <= hit;
          if (hit && op == fjb_pkg::OP_POP) begin
            result.payload_out        <= hit_pay;
            result.payload_length_out <= hit_len;
          end
        end
        fjb_pkg::OP_PREDICT: begin
          if (hit) begin
            result.found              <= 1'b1;
            result.payload_out        <= hit_pay;
            result.payload_length_out <= hit_len;
          end else if (last_len != '0) begin
            result.found              <= 1'b1;
            result.payload_out        <= last_pay;
            result.payload_length_out <= last_len;
          end
        end
        default: begin
          result.found <= 1'b0;
        end
      endcase
      result.delay_frames  <= delay;
      result.highest_frame <= highest;
      result.lowest_frame  <= lowest;
      result.entry_count   <= 7'(count);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fjb_checker.sv -----
// port-level checks for the frame jitter buffer and their binding
`default_nettype none
module fjb_checker #(
  parameter int unsigned CAPACITY = 120
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire fjb_pkg::out_t result
);

  // an accepted transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // the result strobe comes with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe too long");

  // the entry count reported with each result never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(result.entry_count) <= CAPACITY) else $error("entry count over capacity");

endmodule

bind frame_jitter_buffer fjb_checker #(.CAPACITY(CAPACITY)) u_fjb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire
